// ===== rtl/dahdsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Envelope generator package
// Widths, register indexes, segment codes and the divider stage record that
// the delay-attack-decay-sustain-release envelope core shares.
// ----------------------------------------------------------------------------
package dahdsr_pkg;

  localparam int LENGTH_BITS    = 24;
  localparam int LEVEL_BITS     = 16;
  localparam int FRAME_BITS     = 32;
  localparam int SUM_BITS       = LENGTH_BITS + 3;
  localparam int PRODUCT_BITS   = LENGTH_BITS + LEVEL_BITS;
  localparam int CFG_DATA_BITS  = (LENGTH_BITS > LEVEL_BITS) ? LENGTH_BITS : LEVEL_BITS;
  localparam int REG_INDEX_BITS = 3;
  localparam int SEG_BITS       = 3;

  localparam logic [REG_INDEX_BITS-1:0] REG_DELAY   = REG_INDEX_BITS'(0);
  localparam logic [REG_INDEX_BITS-1:0] REG_ATTACK  = REG_INDEX_BITS'(1);
  localparam logic [REG_INDEX_BITS-1:0] REG_DECAY   = REG_INDEX_BITS'(2);
  localparam logic [REG_INDEX_BITS-1:0] REG_SUSTAIN = REG_INDEX_BITS'(3);
  localparam logic [REG_INDEX_BITS-1:0] REG_RELEASE = REG_INDEX_BITS'(4);
  localparam logic [REG_INDEX_BITS-1:0] REG_PEAK    = REG_INDEX_BITS'(5);
  localparam logic [REG_INDEX_BITS-1:0] REG_HOLD    = REG_INDEX_BITS'(6);

  localparam logic [SEG_BITS-1:0] SEG_ZERO    = SEG_BITS'(0);
  localparam logic [SEG_BITS-1:0] SEG_ATTACK  = SEG_BITS'(1);
  localparam logic [SEG_BITS-1:0] SEG_DECAY   = SEG_BITS'(2);
  localparam logic [SEG_BITS-1:0] SEG_SUSTAIN = SEG_BITS'(3);
  localparam logic [SEG_BITS-1:0] SEG_RELEASE = SEG_BITS'(4);

  typedef struct packed {
    logic [LENGTH_BITS-1:0] rem;
    logic [LEVEL_BITS-1:0]  nlow;
    logic [LEVEL_BITS-1:0]  quo;
    logic [LENGTH_BITS-1:0] len;
    logic [LEVEL_BITS-1:0]  start;
    logic                   up;
    logic                   fin;
    logic                   eob;
  } div_stage_t;

endpackage

// ===== rtl/delay_adsr_envelope_generator_core.sv =====
// ----------------------------------------------------------------------------
// Delay-attack-decay-sustain-release envelope generator core
// Returns the linear envelope level, the finished flag and the block-end mark
// for each frame index, with ramps computed by a pipelined divider.
// ----------------------------------------------------------------------------
// The core takes one frame transaction every clock cycle unless stalled and
// returns one result transaction for each, in order. Most of the pipeline is
// the restoring divider for offset * delta / length, resolving one quotient
// bit per stage. A stall on the result side freezes the whole pipeline and
// is passed back on item_stall in the same cycle. The user must write
// configuration only while no transaction is in flight; it is not enforced.
module delay_adsr_envelope_generator_core (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        write_enable,
  input  logic [dahdsr_pkg::REG_INDEX_BITS-1:0]       register_index,
  input  logic [dahdsr_pkg::CFG_DATA_BITS-1:0]        write_data,
  input  logic                                        item_valid,
  output logic                                        item_stall,
  input  logic [dahdsr_pkg::FRAME_BITS-1:0]           frame_index,
  input  logic                                        end_of_block,
  output logic                                        result_valid,
  input  logic                                        result_stall,
  output logic [dahdsr_pkg::LEVEL_BITS-1:0]           level,
  output logic                                        finished,
  output logic                                        last_of_block
);

  localparam int L = dahdsr_pkg::LENGTH_BITS;
  localparam int Q = dahdsr_pkg::LEVEL_BITS;
  localparam int F = dahdsr_pkg::FRAME_BITS;
  localparam int S = dahdsr_pkg::SUM_BITS;
  localparam int P = dahdsr_pkg::PRODUCT_BITS;

  logic [L-1:0] delay_frames;
  logic [L-1:0] attack_frames;
  logic [L-1:0] decay_frames;
  logic [L-1:0] sustain_frames;
  logic [L-1:0] release_frames;
  logic [Q-1:0] peak_level;
  logic [Q-1:0] hold_level;

  logic [S-1:0] sum_da;
  logic [S-1:0] sum_ds;
  logic [L-1:0] delay_copy;
  logic [L-1:0] decay_copy;
  logic [L-1:0] release_copy;
  logic [S-1:0] bound_1;
  logic [S-1:0] bound_2;
  logic [S-1:0] bound_3;
  logic [S-1:0] bound_4;
  logic [S-1:0] bound_end;

  logic en;

  logic         s1_valid;
  logic [F-1:0] s1_frame;
  logic         s1_eob;
  logic         s2_valid;
  logic [F-1:0] s2_frame;
  logic         s2_eob;

  logic                              s3_valid;
  logic [dahdsr_pkg::SEG_BITS-1:0]   s3_seg;
  logic [L-1:0]                      s3_off;
  logic                              s3_fin;
  logic                              s3_eob;
  logic [dahdsr_pkg::SEG_BITS-1:0]   s3_seg_next;
  logic [L-1:0]                      s3_off_next;
  logic                              s3_fin_next;
  logic [F-1:0]                      diff_1;
  logic [F-1:0]                      diff_2;
  logic [F-1:0]                      diff_4;

  logic         s4_valid;
  logic [L-1:0] s4_off;
  logic [Q-1:0] s4_mag;
  logic [L-1:0] s4_len;
  logic [Q-1:0] s4_start;
  logic         s4_up;
  logic         s4_fin;
  logic         s4_eob;
  logic [L-1:0] s4_off_next;
  logic [Q-1:0] s4_mag_next;
  logic [L-1:0] s4_len_next;
  logic [Q-1:0] s4_start_next;
  logic         s4_up_next;

  logic [P-1:0] product;

  dahdsr_pkg::div_stage_t dv [Q+1];
  logic [Q:0]             dv_valid;
  dahdsr_pkg::div_stage_t dv_first;
  dahdsr_pkg::div_stage_t dv_step [Q];
  logic [L:0]             trial [Q];
  logic [L:0]             trial_sub [Q];

  logic [Q-1:0] level_next;

  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_frames   <= '0;
      attack_frames  <= '0;
      decay_frames   <= '0;
      sustain_frames <= '0;
      release_frames <= '0;
      peak_level     <= '1;
      hold_level     <= Q'(1) << (Q - 1);
    end else if (write_enable) begin
      case (register_index)
        dahdsr_pkg::REG_DELAY:   delay_frames   <= write_data[L-1:0];
        dahdsr_pkg::REG_ATTACK:  attack_frames  <= write_data[L-1:0];
        dahdsr_pkg::REG_DECAY:   decay_frames   <= write_data[L-1:0];
        dahdsr_pkg::REG_SUSTAIN: sustain_frames <= write_data[L-1:0];
        dahdsr_pkg::REG_RELEASE: release_frames <= write_data[L-1:0];
        dahdsr_pkg::REG_PEAK:    peak_level     <= write_data[Q-1:0];
        dahdsr_pkg::REG_HOLD:    hold_level     <= write_data[Q-1:0];
        default: ;
      endcase
    end
  end

  // Segment boundaries are registered behind the sums and copies of the lengths.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_da       <= '0;
      sum_ds       <= '0;
      delay_copy   <= '0;
      decay_copy   <= '0;
      release_copy <= '0;
      bound_1      <= '0;
      bound_2      <= '0;
      bound_3      <= '0;
      bound_4      <= '0;
      bound_end    <= '0;
    end else begin
      sum_da       <= S'(delay_frames) + S'(attack_frames);
      sum_ds       <= S'(decay_frames) + S'(sustain_frames);
      delay_copy   <= delay_frames;
      decay_copy   <= decay_frames;
      release_copy <= release_frames;
      bound_1      <= S'(delay_copy);
      bound_2      <= sum_da;
      bound_3      <= sum_da + S'(decay_copy);
      bound_4      <= sum_da + sum_ds;
      bound_end    <= sum_da + sum_ds + S'(release_copy);
    end
  end

  always_comb begin
    diff_1      = s2_frame - F'(bound_1);
    diff_2      = s2_frame - F'(bound_2);
    diff_4      = s2_frame - F'(bound_4);
    s3_fin_next = (s2_frame >= F'(bound_end));
    s3_seg_next = dahdsr_pkg::SEG_ZERO;
    s3_off_next = '0;
    if (s3_fin_next || s2_frame < F'(bound_1)) begin
      s3_seg_next = dahdsr_pkg::SEG_ZERO;
    end else if (s2_frame < F'(bound_2)) begin
      s3_seg_next = dahdsr_pkg::SEG_ATTACK;
      s3_off_next = diff_1[L-1:0];
    end else if (s2_frame < F'(bound_3)) begin
      s3_seg_next = dahdsr_pkg::SEG_DECAY;
      s3_off_next = diff_2[L-1:0];
    end else if (s2_frame < F'(bound_4)) begin
      s3_seg_next = dahdsr_pkg::SEG_SUSTAIN;
    end else begin
      s3_seg_next = dahdsr_pkg::SEG_RELEASE;
      s3_off_next = diff_4[L-1:0];
    end
  end

  always_comb begin
    s4_off_next   = s3_off;
    s4_mag_next   = '0;
    s4_len_next   = L'(1);
    s4_start_next = '0;
    s4_up_next    = 1'b1;
    case (s3_seg)
      dahdsr_pkg::SEG_ATTACK: begin
        s4_mag_next = peak_level;
        s4_len_next = attack_frames;
      end
      dahdsr_pkg::SEG_DECAY: begin
        s4_start_next = peak_level;
        s4_len_next   = decay_frames;
        if (hold_level >= peak_level) begin
          s4_mag_next = hold_level - peak_level;
        end else begin
          s4_mag_next = peak_level - hold_level;
          s4_up_next  = 1'b0;
        end
      end
      dahdsr_pkg::SEG_SUSTAIN: begin
        s4_start_next = hold_level;
        s4_off_next   = '0;
      end
      dahdsr_pkg::SEG_RELEASE: begin
        s4_start_next = hold_level;
        s4_mag_next   = hold_level;
        s4_len_next   = release_frames;
        s4_up_next    = 1'b0;
      end
      default: begin
        s4_off_next = '0;
      end
    endcase
  end

  assign product = s4_off * s4_mag;

  always_comb begin
    dv_first.rem   = product[P-1:Q];
    dv_first.nlow  = product[Q-1:0];
    dv_first.quo   = '0;
    dv_first.len   = s4_len;
    dv_first.start = s4_start;
    dv_first.up    = s4_up;
    dv_first.fin   = s4_fin;
    dv_first.eob   = s4_eob;
  end

  always_comb begin
    for (int k = 0; k < Q; k++) begin
      trial[k]        = {dv[k].rem, dv[k].nlow[Q-1]};
      trial_sub[k]    = trial[k] - {1'b0, dv[k].len};
      dv_step[k]      = dv[k];
      dv_step[k].nlow = dv[k].nlow << 1;
      if (trial[k] >= {1'b0, dv[k].len}) begin
        dv_step[k].rem = trial_sub[k][L-1:0];
        dv_step[k].quo = {dv[k].quo[Q-2:0], 1'b1};
      end else begin
        dv_step[k].rem = trial[k][L-1:0];
        dv_step[k].quo = {dv[k].quo[Q-2:0], 1'b0};
      end
    end
  end

  assign level_next = dv[Q].up ? (dv[Q].start + dv[Q].quo) : (dv[Q].start - dv[Q].quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      dv_valid     <= '0;
      result_valid <= 1'b0;
    end else if (en) begin
      s1_valid     <= item_valid;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      s4_valid     <= s3_valid;
      dv_valid     <= {dv_valid[Q-1:0], s4_valid};
      result_valid <= dv_valid[Q];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_frame <= frame_index;
      s1_eob   <= end_of_block;
      s2_frame <= s1_frame;
      s2_eob   <= s1_eob;
      s3_seg   <= s3_seg_next;
      s3_off   <= s3_off_next;
      s3_fin   <= s3_fin_next;
      s3_eob   <= s2_eob;
      s4_off   <= s4_off_next;
      s4_mag   <= s4_mag_next;
      s4_len   <= s4_len_next;
      s4_start <= s4_start_next;
      s4_up    <= s4_up_next;
      s4_fin   <= s3_fin;
      s4_eob   <= s3_eob;
      dv[0]    <= dv_first;
      for (int k = 0; k < Q; k++) begin
        dv[k+1] <= dv_step[k];
      end
      level         <= level_next;
      finished      <= dv[Q].fin;
      last_of_block <= dv[Q].eob;
    end
  end

  a_finished_level_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && finished |-> level == '0)
    else $error("Finished result carries a nonzero level.");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    dv_valid[0] |-> dv[0].len != '0)
    else $error("Divider entered with a zero length.");

  a_remainder_bound: assert property (@(posedge clk) disable iff (rst)
    dv_valid[Q] |-> dv[Q].rem < dv[Q].len)
    else $error("Divider remainder is not below the length.");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !result_valid && dv_valid == '0)
    else $error("Pipeline holds a transaction after reset.");

endmodule
